// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker module of the project
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define UTB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition in one cycle implies a consequence in the next cycle
`define UTB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/utb_pkg.sv =====
// ----------------------------------------------------------------------------
// utb_pkg
// Types, constants and the code point classifier of the UTF-8 tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package utb_pkg;

  localparam int unsigned CpW    = 21;
  localparam int unsigned ByteW  = 8;
  // three held bytes plus the current byte or the assembled code point
  localparam int unsigned Slots  = 4;
  // slots plus the end-of-text marker
  localparam int unsigned ListW  = Slots + 1;
  localparam int unsigned EndIdx = Slots;
  localparam int unsigned HoldN  = 3;

  localparam logic [CpW-1:0] CpRepl     = 21'h00FFFD;
  localparam logic [CpW-1:0] CpCombLo   = 21'h000300;
  localparam logic [CpW-1:0] CpCombHi   = 21'h00036F;
  localparam logic [CpW-1:0] CpNbsp     = 21'h0000A0;
  localparam logic [CpW-1:0] CpDel      = 21'h00007F;
  localparam logic [CpW-1:0] CpC1Hi     = 21'h00009F;
  localparam logic [CpW-1:0] CpSpace    = 21'h000020;
  localparam logic [CpW-1:0] CpTab      = 21'h000009;
  localparam logic [CpW-1:0] CpLf       = 21'h00000A;
  localparam logic [CpW-1:0] CpCr       = 21'h00000D;
  localparam logic [CpW-1:0] CpUpperLo  = 21'h000041;
  localparam logic [CpW-1:0] CpUpperHi  = 21'h00005A;
  localparam logic [CpW-1:0] CpCaseOfs  = 21'h000020;

  // length of the open multi-byte sequence
  typedef enum logic [2:0] {
    SEQ_NONE  = 3'd0,
    SEQ_TWO   = 3'd2,
    SEQ_THREE = 3'd3,
    SEQ_FOUR  = 3'd4
  } utb_seq_e;

  // code points caused by one byte, in output order
  typedef struct packed {
    logic [ListW-1:0]          keep;
    logic [Slots-1:0][CpW-1:0] cp;
    logic [Slots-1:0]          start;
  } utb_list_t;

  typedef struct packed {
    logic           drop;
    logic           space;
    logic           single;
    logic [CpW-1:0] cp;
  } utb_class_t;

  function automatic logic in_rng(input logic [CpW-1:0] cp, input logic [CpW-1:0] lo,
                                  input logic [CpW-1:0] hi);
    return (cp >= lo) && (cp <= hi);
  endfunction

  function automatic utb_class_t classify(input logic [CpW-1:0] cp, input logic lower);
    utb_class_t     res;
    logic           ctrl;
    logic           punct;
    logic           cjk;
    logic [CpW-1:0] lc;
    ctrl = ((cp < CpSpace) && (cp != CpTab) && (cp != CpLf) && (cp != CpCr))
           || in_rng(cp, CpDel, CpC1Hi);
    res.drop  = (cp == '0) || (cp == CpRepl) || ctrl || in_rng(cp, CpCombLo, CpCombHi);
    res.space = !res.drop && ((cp == CpSpace) || (cp == CpTab) || (cp == CpLf)
                              || (cp == CpCr) || (cp == CpNbsp));
    lc = (lower && in_rng(cp, CpUpperLo, CpUpperHi)) ? cp + CpCaseOfs : cp;
    punct = in_rng(lc, 21'd33, 21'd47) || in_rng(lc, 21'd58, 21'd64)
            || in_rng(lc, 21'd91, 21'd96) || in_rng(lc, 21'd123, 21'd126);
    cjk = in_rng(lc, 21'h04E00, 21'h09FFF) || in_rng(lc, 21'h03400, 21'h04DBF)
          || in_rng(lc, 21'h20000, 21'h2A6DF) || in_rng(lc, 21'h2A700, 21'h2B73F)
          || in_rng(lc, 21'h2B740, 21'h2B81F) || in_rng(lc, 21'h2B820, 21'h2CEAF)
          || in_rng(lc, 21'h0F900, 21'h0FAFF) || in_rng(lc, 21'h2F800, 21'h2FA1F);
    res.single = punct || cjk;
    res.cp     = lc;
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/utf8_basic_text_tokenizer.sv =====
// Takes UTF-8 text one byte per request and returns kept code points, each
// flagged when it starts a token, plus an end-of-text marker after the last
// byte. A byte that yields zero or one result is taken every cycle while the
// output is not stalled; a byte that yields more (up to five, on a broken
// sequence or at text end) holds the input until all but its last result are
// sent, as the output stage sends one result per cycle when not stalled. A
// result passes the input, result list and output registers in that order.
// ----------------------------------------------------------------------------
// utf8_basic_text_tokenizer
// Top level: input register, configuration register, decoder and serializer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf8_basic_text_tokenizer (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [utb_pkg::ByteW-1:0] data_byte_i,
  input  wire logic                      last_byte_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic                           kind_o,
  output logic [utb_pkg::CpW-1:0]        code_point_o,
  output logic                           starts_token_o,
  output logic                           run_last_o
);

  logic                      lower_case_q;
  logic                      in_v_q, in_v_d;
  logic [utb_pkg::ByteW-1:0] byte_q;
  logic                      last_q;
  logic                      in_load;
  logic                      in_move;
  logic                      list_free;
  utb_pkg::utb_list_t        list;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_case_q <= 1'b1;
    end else if (cfg_we_i) begin
      lower_case_q <= cfg_wdata_i;
    end
  end

  // input register
  assign in_move    = in_v_q && list_free;
  assign in_stall_o = in_v_q && !in_move;
  assign in_load    = in_valid_i && !in_stall_o;

  always_comb begin
    in_v_d = in_v_q;
    if (in_load) begin
      in_v_d = 1'b1;
    end else if (in_move) begin
      in_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= in_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  utb_decoder u_decoder (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (in_move),
    .data_byte_i  (byte_q),
    .last_byte_i  (last_q),
    .lower_case_i (lower_case_q),
    .list_o       (list)
  );

  utb_serializer u_serializer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (in_move),
    .list_i         (list),
    .free_o         (list_free),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .code_point_o   (code_point_o),
    .starts_token_o (starts_token_o),
    .run_last_o     (run_last_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/utb_decoder.sv =====
// ----------------------------------------------------------------------------
// utb_decoder
// Lenient UTF-8 decode, classification and token start marking of one byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utb_decoder (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    advance_i,
  input  wire logic [utb_pkg::ByteW-1:0] data_byte_i,
  input  wire logic                    last_byte_i,
  input  wire logic                    lower_case_i,
  output utb_pkg::utb_list_t           list_o
);

  logic [utb_pkg::ByteW-1:0] pend_q [utb_pkg::HoldN];
  logic [utb_pkg::ByteW-1:0] pend_d [utb_pkg::HoldN];
  logic [1:0]                cnt_q, cnt_d;
  utb_pkg::utb_seq_e         seq_q, seq_d;
  logic                      word_open_q, word_open_d;

  logic                      cont;
  logic                      complete;
  utb_pkg::utb_seq_e         lead_len;
  logic [utb_pkg::HoldN-1:0] flush_mask;
  logic                      byte_raw;
  logic                      asm_v;
  logic [utb_pkg::CpW-1:0]   asm_cp;

  // lead byte length
  assign cont     = (data_byte_i[7:6] == 2'b10);
  assign complete = ({1'b0, cnt_q} + 3'd1) >= 3'(seq_q);

  always_comb begin
    if (data_byte_i[7:5] == 3'b110) begin
      lead_len = utb_pkg::SEQ_TWO;
    end else if (data_byte_i[7:4] == 4'b1110) begin
      lead_len = utb_pkg::SEQ_THREE;
    end else if (data_byte_i[7:3] == 5'b11110) begin
      lead_len = utb_pkg::SEQ_FOUR;
    end else begin
      lead_len = utb_pkg::SEQ_NONE;
    end
  end

  // sequence assembly
  always_comb begin
    unique case (seq_q)
      utb_pkg::SEQ_TWO:   asm_cp = {10'd0, pend_q[0][4:0], data_byte_i[5:0]};
      utb_pkg::SEQ_THREE: asm_cp = {5'd0, pend_q[0][3:0], pend_q[1][5:0], data_byte_i[5:0]};
      utb_pkg::SEQ_FOUR:  asm_cp = {pend_q[0][2:0], pend_q[1][5:0], pend_q[2][5:0],
                                    data_byte_i[5:0]};
      default:            asm_cp = '0;
    endcase
  end

  // sequence state and which code points this byte releases
  always_comb begin
    logic take_lead;
    take_lead  = 1'b0;
    flush_mask = '0;
    byte_raw   = 1'b0;
    asm_v      = 1'b0;
    cnt_d      = cnt_q;
    seq_d      = seq_q;
    pend_d     = pend_q;
    if (seq_q != utb_pkg::SEQ_NONE) begin
      if (cont) begin
        if (complete) begin
          asm_v = 1'b1;
          cnt_d = '0;
          seq_d = utb_pkg::SEQ_NONE;
        end else if (last_byte_i) begin
          for (int i = 0; i < utb_pkg::HoldN; i++) begin
            flush_mask[i] = (2'(i) < cnt_q);
          end
          byte_raw = 1'b1;
          cnt_d    = '0;
          seq_d    = utb_pkg::SEQ_NONE;
        end else begin
          for (int i = 0; i < utb_pkg::HoldN; i++) begin
            if (cnt_q == 2'(i)) begin
              pend_d[i] = data_byte_i;
            end
          end
          cnt_d = cnt_q + 2'd1;
        end
      end else begin
        for (int i = 0; i < utb_pkg::HoldN; i++) begin
          flush_mask[i] = (2'(i) < cnt_q);
        end
        cnt_d     = '0;
        seq_d     = utb_pkg::SEQ_NONE;
        take_lead = 1'b1;
      end
    end else begin
      take_lead = 1'b1;
    end
    if (take_lead) begin
      if ((lead_len == utb_pkg::SEQ_NONE) || last_byte_i) begin
        byte_raw = 1'b1;
      end else begin
        pend_d[0] = data_byte_i;
        cnt_d     = 2'd1;
        seq_d     = lead_len;
      end
    end
  end

  // classify each slot and chain the open word flag through them
  always_comb begin
    logic                    wo;
    logic                    present;
    logic [utb_pkg::CpW-1:0] slot_cp;
    utb_pkg::utb_class_t     cls;
    wo     = word_open_q;
    list_o = '0;
    for (int i = 0; i < utb_pkg::Slots; i++) begin
      if (i < utb_pkg::HoldN) begin
        present = flush_mask[i];
        slot_cp = {{(utb_pkg::CpW - utb_pkg::ByteW){1'b0}}, pend_q[i]};
      end else begin
        present = byte_raw || asm_v;
        slot_cp = asm_v ? asm_cp
                        : {{(utb_pkg::CpW - utb_pkg::ByteW){1'b0}}, data_byte_i};
      end
      cls          = utb_pkg::classify(slot_cp, lower_case_i);
      list_o.cp[i] = cls.cp;
      if (present && !cls.drop) begin
        if (cls.space) begin
          wo = 1'b0;
        end else if (cls.single) begin
          list_o.keep[i]  = 1'b1;
          list_o.start[i] = 1'b1;
          wo              = 1'b0;
        end else begin
          list_o.keep[i]  = 1'b1;
          list_o.start[i] = !wo;
          wo              = 1'b1;
        end
      end
    end
    list_o.keep[utb_pkg::EndIdx] = last_byte_i;
    word_open_d = last_byte_i ? 1'b0 : wo;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      seq_q       <= utb_pkg::SEQ_NONE;
      word_open_q <= 1'b0;
    end else if (advance_i) begin
      cnt_q       <= cnt_d;
      seq_q       <= seq_d;
      word_open_q <= word_open_d;
    end
  end

  // held sequence bytes
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      pend_q <= pend_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/utb_serializer.sv =====
// ----------------------------------------------------------------------------
// utb_serializer
// Holds the code points of one byte and sends them out one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utb_serializer (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    load_i,
  input  wire utb_pkg::utb_list_t      list_i,
  output logic                         free_o,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic                         kind_o,
  output logic [utb_pkg::CpW-1:0]      code_point_o,
  output logic                         starts_token_o,
  output logic                         run_last_o
);

  logic [utb_pkg::ListW-1:0]          rem_q, rem_d;
  logic [utb_pkg::Slots-1:0][utb_pkg::CpW-1:0] cp_q;
  logic [utb_pkg::Slots-1:0]          start_q;
  logic                               out_v_q, out_v_d;
  logic                               kind_q;
  logic [utb_pkg::CpW-1:0]            cpo_q;
  logic                               start_o_q;
  logic                               last_o_q;

  logic [utb_pkg::ListW-1:0] pick;
  logic [utb_pkg::ListW-1:0] rest;
  logic                      out_load;
  logic                      emit;
  logic [utb_pkg::CpW-1:0]   pick_cp;
  logic                      pick_start;

  // lowest pending entry goes next
  assign pick     = rem_q & (~rem_q + utb_pkg::ListW'(1));
  assign rest     = rem_q & ~pick;
  assign out_load = !out_v_q || !out_stall_i;
  assign emit     = (rem_q != '0) && out_load;
  assign free_o   = (rem_q == '0) || ((rest == '0) && out_load);

  always_comb begin
    pick_cp    = '0;
    pick_start = 1'b0;
    for (int i = 0; i < utb_pkg::Slots; i++) begin
      if (pick[i]) begin
        pick_cp    = pick_cp | cp_q[i];
        pick_start = pick_start | start_q[i];
      end
    end
  end

  // pending entry mask
  always_comb begin
    rem_d = rem_q;
    if (load_i) begin
      rem_d = list_i.keep;
    end else if (emit) begin
      rem_d = rest;
    end
    out_v_d = out_load ? emit : out_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      rem_q   <= rem_d;
      out_v_q <= out_v_d;
    end
  end

  // list payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cp_q    <= list_i.cp;
      start_q <= list_i.start;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q    <= pick[utb_pkg::EndIdx];
      cpo_q     <= pick_cp;
      start_o_q <= pick_start;
      last_o_q  <= (rest == '0);
    end
  end

  assign out_valid_o    = out_v_q;
  assign kind_o         = kind_q;
  assign code_point_o   = cpo_q;
  assign starts_token_o = start_o_q;
  assign run_last_o     = last_o_q;

endmodule

`default_nettype wire

// ===== hw/rtl/utb_checker.sv =====
// ----------------------------------------------------------------------------
// utb_checker
// Port-level checks of the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module utb_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_stall_o,
  input wire logic [utb_pkg::ByteW-1:0] data_byte_i,
  input wire logic                      last_byte_i,
  input wire logic                      out_valid_o,
  input wire logic                      out_stall_i,
  input wire logic                      kind_o,
  input wire logic [utb_pkg::CpW-1:0]   code_point_o,
  input wire logic                      starts_token_o,
  input wire logic                      run_last_o
);

  // a stalled request holds
  `UTB_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_i && in_stall_o, in_valid_i && $stable(data_byte_i) && $stable(last_byte_i), "stalled request changed")

  // a stalled result holds
  `UTB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(code_point_o) && $stable(kind_o), "stalled result changed")

  // end marker carries no code point and closes the byte
  `UTB_ASSERT(a_end_shape, clk_i, rst_ni, out_valid_o && kind_o |-> code_point_o == '0 && !starts_token_o && run_last_o, "malformed end marker")

  // NUL and the replacement character never reach the output
  `UTB_ASSERT(a_no_dropped, clk_i, rst_ni, out_valid_o && !kind_o |-> code_point_o != '0 && code_point_o != utb_pkg::CpRepl, "dropped code point sent")

  // a comma always opens its own token
  `UTB_ASSERT(a_punct_start, clk_i, rst_ni, out_valid_o && !kind_o && code_point_o == 21'h00002C |-> starts_token_o, "punctuation not a token start")

endmodule

bind utf8_basic_text_tokenizer utb_checker u_checker (.*);

`default_nettype wire

// ===== bench/utb_token_checker.sv =====
// ----------------------------------------------------------------------------
// utb_token_checker
// Watches both channels and the configuration port of the tokenizer, works
// out the code points each accepted byte must give, and compares every
// accepted result with the oldest one still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utb_token_checker (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_wdata_i,
  input  wire logic                      in_valid_i,
  input  wire logic                      in_stall_i,
  input  wire logic [utb_pkg::ByteW-1:0] data_byte_i,
  input  wire logic                      last_byte_i,
  input  wire logic                      out_valid_i,
  input  wire logic                      out_stall_i,
  input  wire logic                      kind_i,
  input  wire logic [utb_pkg::CpW-1:0]   code_point_i,
  input  wire logic                      starts_token_i,
  input  wire logic                      run_last_i,
  output int unsigned                    fail_cnt_o,
  output int unsigned                    pend_cnt_o
);

  localparam logic KIND_CP  = 1'b0;
  localparam logic KIND_END = 1'b1;
  localparam int unsigned ShowMax = 10;

  typedef struct packed {
    logic                    kind;
    logic [utb_pkg::CpW-1:0] cp;
    logic                    start;
    logic                    fin;
  } tok_t;

  // tokenizer state as the block should hold it
  logic                      lower_en = 1'b1;
  logic [utb_pkg::ByteW-1:0] seq_buf[utb_pkg::HoldN];
  int unsigned               seq_cnt = 0;
  utb_pkg::utb_seq_e         seq_len = utb_pkg::SEQ_NONE;
  logic                      in_word = 1'b0;

  tok_t        step_q[$];
  tok_t        tok_due_q[$];
  int unsigned fails = 0;

  task automatic emit(input logic kind, input logic [utb_pkg::CpW-1:0] cp,
                      input logic start);
    tok_t t;
    t.kind  = kind;
    t.cp    = cp;
    t.start = start;
    t.fin   = 1'b0;
    step_q  = {step_q, t};
  endtask

  // drop, close the word, or keep a code point with its token start flag
  task automatic keep_cp(input logic [utb_pkg::CpW-1:0] cp_in);
    logic [utb_pkg::CpW-1:0] cp;
    logic                    ctrl;
    logic                    single;
    cp = cp_in;
    ctrl = ((cp < 21'h20) && (cp != 21'h09) && (cp != 21'h0A) && (cp != 21'h0D))
           || ((cp >= 21'h7F) && (cp <= 21'h9F));
    if (ctrl || (cp == 21'hFFFD) || ((cp >= 21'h300) && (cp <= 21'h36F))) return;
    if ((cp == 21'h20) || (cp == 21'h09) || (cp == 21'h0A) || (cp == 21'h0D)
        || (cp == 21'hA0)) begin
      in_word = 1'b0;
      return;
    end
    if (lower_en && (cp >= 21'h41) && (cp <= 21'h5A)) cp = cp + 21'h20;
    single = ((cp >= 33) && (cp <= 47)) || ((cp >= 58) && (cp <= 64))
             || ((cp >= 91) && (cp <= 96)) || ((cp >= 123) && (cp <= 126))
             || ((cp >= 21'h4E00) && (cp <= 21'h9FFF))
             || ((cp >= 21'h3400) && (cp <= 21'h4DBF))
             || ((cp >= 21'h20000) && (cp <= 21'h2A6DF))
             || ((cp >= 21'h2A700) && (cp <= 21'h2CEAF))
             || ((cp >= 21'hF900) && (cp <= 21'hFAFF))
             || ((cp >= 21'h2F800) && (cp <= 21'h2FA1F));
    if (single) begin
      in_word = 1'b0;
      emit(KIND_CP, cp, 1'b1);
      return;
    end
    emit(KIND_CP, cp, !in_word);
    in_word = 1'b1;
  endtask

  // held bytes of a broken sequence come out as raw code points
  task automatic flush_held();
    for (int i = 0; i < seq_cnt; i++) keep_cp({13'd0, seq_buf[i]});
    seq_cnt = 0;
    seq_len = utb_pkg::SEQ_NONE;
  endtask

  task automatic take_lead(input logic [utb_pkg::ByteW-1:0] b, input logic fin);
    utb_pkg::utb_seq_e len;
    if (b[7:5] == 3'b110) len = utb_pkg::SEQ_TWO;
    else if (b[7:4] == 4'b1110) len = utb_pkg::SEQ_THREE;
    else if (b[7:3] == 5'b11110) len = utb_pkg::SEQ_FOUR;
    else len = utb_pkg::SEQ_NONE;
    if ((len == utb_pkg::SEQ_NONE) || fin) begin
      keep_cp({13'd0, b});
    end else begin
      seq_buf[0] = b;
      seq_cnt    = 1;
      seq_len    = len;
    end
  endtask

  // results due for one accepted byte, queued in output order
  task automatic tokenize_byte(input logic [utb_pkg::ByteW-1:0] b, input logic fin);
    logic [31:0] acc;
    int          idx;
    step_q.delete();
    if (seq_len != utb_pkg::SEQ_NONE) begin
      if (b[7:6] == 2'b10) begin
        if (seq_cnt + 1 >= int'(seq_len)) begin
          case (seq_len)
            utb_pkg::SEQ_TWO:   acc = {27'd0, seq_buf[0][4:0]};
            utb_pkg::SEQ_THREE: acc = {28'd0, seq_buf[0][3:0]};
            default:            acc = {29'd0, seq_buf[0][2:0]};
          endcase
          for (int i = 1; i < seq_cnt; i++) acc = (acc << 6) | {26'd0, seq_buf[i][5:0]};
          acc = (acc << 6) | {26'd0, b[5:0]};
          seq_cnt = 0;
          seq_len = utb_pkg::SEQ_NONE;
          keep_cp(acc[utb_pkg::CpW-1:0]);
        end else if (fin) begin
          flush_held();
          keep_cp({13'd0, b});
        end else begin
          seq_buf[seq_cnt] = b;
          seq_cnt++;
        end
      end else begin
        flush_held();
        take_lead(b, fin);
      end
    end else begin
      take_lead(b, fin);
    end
    if (fin) begin
      in_word = 1'b0;
      emit(KIND_END, '0, 1'b0);
    end
    if (step_q.size() > 0) begin
      idx = step_q.size() - 1;
      step_q[idx].fin = 1'b1;
    end
    tok_due_q = {tok_due_q, step_q};
  endtask

  // compare one accepted result with the oldest one due
  task automatic check_result();
    tok_t want;
    if (tok_due_q.size() == 0) begin
      fails++;
      if (fails <= ShowMax)
        $display("%0t: result with none due: kind %0d cp %h start %0d last %0d", $time,
                 kind_i, code_point_i, starts_token_i, run_last_i);
      return;
    end
    want = tok_due_q.pop_front();
    if ((want.kind != kind_i) || (want.cp != code_point_i) || (want.start != starts_token_i)
        || (want.fin != run_last_i)) begin
      fails++;
      if (fails <= ShowMax)
        $display("%0t: mismatch: want kind %0d cp %h start %0d last %0d, got %0d %h %0d %0d",
                 $time, want.kind, want.cp, want.start, want.fin,
                 kind_i, code_point_i, starts_token_i, run_last_i);
    end
  endtask

  // sample both channels and the register write at every edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_en = 1'b1;
      seq_cnt  = 0;
      seq_len  = utb_pkg::SEQ_NONE;
      in_word  = 1'b0;
      tok_due_q.delete();
      fail_cnt_o <= fails;
      pend_cnt_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result();
      if (cfg_we_i) lower_en = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) tokenize_byte(data_byte_i, last_byte_i);
      fail_cnt_o <= fails;
      pend_cnt_o <= tok_due_q.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives the tokenizer with short directed texts and random UTF-8 texts,
// mostly well formed with some broken sequences and stray bytes, under both
// case settings and random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic                      cfg_wdata = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [utb_pkg::ByteW-1:0] data_byte = '0;
  logic                      last_byte = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      kind;
  logic [utb_pkg::CpW-1:0]   code_point;
  logic                      starts_token;
  logic                      run_last;
  int unsigned               fail_cnt;
  int unsigned               pend_cnt;

  int unsigned stall_pct = 0;
  int unsigned stall_left = 0;
  int unsigned gap_pct = 0;
  logic [7:0]  text_q[$];

  utf8_basic_text_tokenizer dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .data_byte_i    (data_byte),
    .last_byte_i    (last_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .kind_o         (kind),
    .code_point_o   (code_point),
    .starts_token_o (starts_token),
    .run_last_o     (run_last)
  );

  utb_token_checker chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .data_byte_i    (data_byte),
    .last_byte_i    (last_byte),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .kind_i         (kind),
    .code_point_i   (code_point),
    .starts_token_i (starts_token),
    .run_last_i     (run_last),
    .fail_cnt_o     (fail_cnt),
    .pend_cnt_o     (pend_cnt)
  );

  always #6 clk = ~clk;

  // receiver stalls in bursts of random length
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (rst_n && ($urandom_range(0, 99) < stall_pct)) begin
      stall_left = $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // one byte request, with an optional gap in front of it
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if ((gap_pct != 0) && ($urandom_range(0, 99) < gap_pct)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  // let every due result arrive and the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pend_cnt != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_lower_case(input logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // append one byte to the text
  task automatic add_byte(input logic [7:0] b);
    text_q = {text_q, b};
  endtask

  // UTF-8 encoding of one code point
  task automatic put_cp(input logic [20:0] cp);
    if (cp < 21'h80) begin
      add_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      add_byte({3'b110, cp[10:6]});
      add_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      add_byte({4'b1110, cp[15:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end else begin
      add_byte({5'b11110, cp[20:18]});
      add_byte({2'b10, cp[17:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end
  endtask

  function automatic logic [20:0] wide_cp();
    case ($urandom_range(0, 7))
      0: return 21'($urandom_range('h300, 'h36F));
      1: return 21'($urandom_range('h80, 'h7FF));
      2: return 21'($urandom_range('h4E00, 'h9FFF));
      3: return ($urandom_range(0, 1) != 0) ? 21'hFFFD : 21'($urandom_range('hF900, 'hFAFF));
      4: return 21'($urandom_range('h800, 'hFFFF));
      5: return 21'($urandom_range('h20000, 'h2FA1F));
      6: return 21'($urandom_range('h10000, 'h1FFFFF));
      default: return 21'hA0;
    endcase
  endfunction

  // random text, mostly well formed, with stray bytes and cut sequences
  task automatic build_text(input int unsigned n_chars);
    int unsigned keep_n;
    int unsigned cut;
    text_q.delete();
    repeat (n_chars) begin
      case ($urandom_range(0, 9))
        0: put_cp(21'($urandom_range('h41, 'h5A)));
        1: put_cp(21'($urandom_range('h61, 'h7A)));
        2: put_cp(21'($urandom_range('h21, 'h7E)));
        3: case ($urandom_range(0, 3))
             0: put_cp(21'h20);
             1: put_cp(21'h09);
             2: put_cp(21'h0A);
             default: put_cp(21'h0D);
           endcase
        4: put_cp(($urandom_range(0, 4) == 0) ? 21'h7F : 21'($urandom_range(0, 'h1F)));
        5, 6, 7: put_cp(wide_cp());
        8: add_byte(8'($urandom_range(0, 255)));
        default: begin
          keep_n = text_q.size();
          put_cp(21'($urandom_range('h80, 'h1FFFFF)));
          cut = $urandom_range(1, text_q.size() - keep_n - 1);
          repeat (cut) text_q = text_q[0:$-1];
        end
      endcase
    end
  endtask

  task automatic run_random(input int unsigned n_bytes);
    int unsigned sent;
    sent = 0;
    while (sent < n_bytes) begin
      build_text($urandom_range(1, 10));
      sent += text_q.size();
      send_text();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, case folding from reset: whitespace, punctuation, NUL,
    // two to four byte forms, combining mark, stray continuation, broken
    // sequence, no-break space, replacement char, lead on the final byte
    stall_pct <= 20;
    gap_pct = 20;
    text_q = '{8'h20, 8'h21, 8'h00, 8'hC3, 8'hA9, 8'hCC, 8'h81, 8'hE4, 8'hB8, 8'h80,
               8'hF0, 8'hA0, 8'h80, 8'h80, 8'h80, 8'hE4, 8'hB8, 8'h5A, 8'hC2, 8'hA0,
               8'hEF, 8'hBF, 8'hBD, 8'hC3};
    send_text();
    drain();

    // no case folding; invalid lead and a cut sequence before the final byte
    set_lower_case(1'b0);
    text_q = '{8'hFF, 8'h5A, 8'hF0, 8'hBF, 8'hBF, 8'h41};
    send_text();
    run_random(30);
    drain();

    set_lower_case(1'b1);
    stall_pct <= 40;
    gap_pct = 35;
    run_random(30);
    drain();

    // closing stretch without idling
    set_lower_case(1'b0);
    stall_pct <= 0;
    gap_pct = 0;
    run_random(30);
    drain();

    if ((fail_cnt == 0) && (pend_cnt == 0)) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/utb_pkg.sv
hw/rtl/utb_decoder.sv
hw/rtl/utb_serializer.sv
hw/rtl/utf8_basic_text_tokenizer.sv
hw/rtl/utb_checker.sv
bench/utb_token_checker.sv
bench/tb.sv
